// ----- src/rgsc_pkg.sv -----
package rgsc_pkg;

  // Sizes fixed by the field widths
  localparam int MAX_N_DEF  = 7;
  localparam int LANES      = 8;
  localparam int LANE_W     = 3;
  localparam int MASK_W     = 7;
  localparam int CNT_W      = 6;
  localparam int TAG_W      = 8;
  localparam int STEP_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Phase lengths in cycles
  localparam int MUL_STEPS = 4;
  localparam int MIX_STEPS = 40;
  localparam int DIV_STEPS = 16;

  localparam logic [CNT_W-1:0] MAX_RESULTS = 6'd35;
  localparam logic [63:0]      SEED_MULT   = 64'd88172645463325252;
  localparam logic [63:0]      SEED_ADD    = 64'd12345;

  typedef enum logic [1:0] {
    CFG_SET_SIZE,
    CFG_SUBSET_SIZE,
    CFG_ALLOWED,
    CFG_SEED
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_MIX,
    ST_START,
    ST_TRY,
    ST_DIV,
    ST_SELECT,
    ST_NARROW,
    ST_EMIT,
    ST_EMPTY
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic              accept;
    logic              start;
    logic              mul;
    logic              draw;
    logic              div;
    logic              sel;
    logic              narrow;
    logic              emit;
    logic              emit_empty;
    logic [STEP_W-1:0] step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic seed_wr;
    logic cnt_zero;
    logic last;
    logic out_free;
  } sts_t;

  // One result transfer
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [MASK_W-1:0] member_mask;
    logic              member_valid;
    logic [CNT_W-1:0]  position;
    logic [CNT_W-1:0]  clique_size;
    logic              new_best;
    logic [CNT_W-1:0]  best_size;
    logic              last;
  } res_t;

  // Number of k-subsets of an n-set, indexed [n][k]
  localparam logic [CNT_W-1:0] BINOM [8][8] = '{
    '{6'd1, 6'd0, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd1, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd2, 6'd1,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd3, 6'd3,  6'd1,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd4, 6'd6,  6'd4,  6'd1,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd5, 6'd10, 6'd10, 6'd5,  6'd1,  6'd0, 6'd0},
    '{6'd1, 6'd6, 6'd15, 6'd20, 6'd15, 6'd6,  6'd1, 6'd0},
    '{6'd1, 6'd7, 6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1}
  };

  function automatic logic [63:0] xs_step(input logic [63:0] s);
    logic [63:0] t;
    t = s ^ (s << 13);
    t = t ^ (t >> 7);
    t = t ^ (t << 17);
    return t;
  endfunction

  function automatic logic [3:0] popcnt8(input logic [7:0] x);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'b000, x[i]};
    end
    return c;
  endfunction

  // Generator state after reset (seed zero), settled at elaboration
  function automatic logic [63:0] reset_state();
    logic [63:0] s;
    s = SEED_ADD;
    for (int i = 0; i < MIX_STEPS; i++) begin
      s = xs_step(s);
    end
    return s;
  endfunction

  localparam logic [63:0] RNG_RESET = reset_state();

  // Two distinct subsets are adjacent when their overlap size is allowed
  function automatic logic adjacent(input logic [MASK_W-1:0] m,
                                    input logic [MASK_W-1:0] v,
                                    input logic [7:0]        allowed);
    logic [3:0] ov;
    ov = popcnt8({1'b0, m & v});
    return (m != v) && allowed[ov[2:0]];
  endfunction

endpackage

// ----- src/rgsc_trial_if.sv -----
interface rgsc_trial_if;
  logic                        valid;
  logic                        ready;
  logic [rgsc_pkg::TAG_W-1:0]  trial_tag;

  modport source (output valid, output trial_tag, input ready);
  modport sink   (input valid, input trial_tag, output ready);
endinterface

// ----- src/rgsc_result_if.sv -----
interface rgsc_result_if;
  logic                         valid;
  logic                         ready;
  logic [rgsc_pkg::TAG_W-1:0]   tag;
  logic [rgsc_pkg::MASK_W-1:0]  member_mask;
  logic                         member_valid;
  logic [rgsc_pkg::CNT_W-1:0]   position;
  logic [rgsc_pkg::CNT_W-1:0]   clique_size;
  logic                         new_best;
  logic [rgsc_pkg::CNT_W-1:0]   best_size;
  logic                         last;

  modport source (output valid, output tag, output member_mask, output member_valid,
                  output position, output clique_size, output new_best,
                  output best_size, output last, input ready);
  modport sink   (input valid, input tag, input member_mask, input member_valid,
                  input position, input clique_size, input new_best,
                  input best_size, input last, output ready);
endinterface

// ----- src/rgsc_ctrl.sv -----
module rgsc_ctrl #(
  parameter int MAX_N = rgsc_pkg::MAX_N_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rgsc_pkg::sts_t sts_i,
  output rgsc_pkg::cmd_t cmd_o
);

  localparam int CAND_W = (MAX_N < 3) ? rgsc_pkg::LANES : (1 << MAX_N);
  localparam int CHUNKS = CAND_W / rgsc_pkg::LANES;
  localparam logic [rgsc_pkg::STEP_W-1:0] LAST_CHUNK = rgsc_pkg::STEP_W'(CHUNKS - 1);
  localparam logic [rgsc_pkg::STEP_W-1:0] LAST_MUL   = rgsc_pkg::STEP_W'(rgsc_pkg::MUL_STEPS - 1);
  localparam logic [rgsc_pkg::STEP_W-1:0] LAST_MIX   = rgsc_pkg::STEP_W'(rgsc_pkg::MIX_STEPS - 1);
  localparam logic [rgsc_pkg::STEP_W-1:0] LAST_DIV   = rgsc_pkg::STEP_W'(rgsc_pkg::DIV_STEPS - 1);

  rgsc_pkg::state_e            state_q, state_d;
  logic [rgsc_pkg::STEP_W-1:0] step_q, step_d;
  logic                        accept;

  assign in_ready_o = (state_q == rgsc_pkg::ST_IDLE) && !sts_i.seed_wr;
  assign accept     = in_valid_i && in_ready_o;

  // State and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rgsc_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    cmd_o    = '0;
    cmd_o.step = step_q;
    if (sts_i.seed_wr) begin
      // a seed write restarts the reseed sequence
      state_d = rgsc_pkg::ST_SEED_MUL;
      step_d  = '0;
    end else begin
      case (state_q)
        rgsc_pkg::ST_IDLE: begin
          cmd_o.accept = accept;
          if (accept) begin
            state_d = rgsc_pkg::ST_START;
          end
        end
        rgsc_pkg::ST_SEED_MUL: begin
          cmd_o.mul = 1'b1;
          if (step_q == LAST_MUL) begin
            state_d = rgsc_pkg::ST_SEED_MIX;
            step_d  = '0;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
        rgsc_pkg::ST_SEED_MIX: begin
          cmd_o.draw = 1'b1;
          if (step_q == LAST_MIX) begin
            state_d = rgsc_pkg::ST_IDLE;
            step_d  = '0;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
        rgsc_pkg::ST_START: begin
          cmd_o.start = 1'b1;
          state_d     = rgsc_pkg::ST_TRY;
        end
        rgsc_pkg::ST_TRY: begin
          if (sts_i.cnt_zero) begin
            state_d = rgsc_pkg::ST_EMPTY;
          end else begin
            cmd_o.draw = 1'b1;
            state_d    = rgsc_pkg::ST_DIV;
            step_d     = '0;
          end
        end
        rgsc_pkg::ST_DIV: begin
          cmd_o.div = 1'b1;
          if (step_q == LAST_DIV) begin
            state_d = rgsc_pkg::ST_SELECT;
            step_d  = '0;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
        rgsc_pkg::ST_SELECT: begin
          cmd_o.sel = 1'b1;
          if (step_q == LAST_CHUNK) begin
            state_d = rgsc_pkg::ST_NARROW;
            step_d  = '0;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
        rgsc_pkg::ST_NARROW: begin
          cmd_o.narrow = 1'b1;
          if (step_q == LAST_CHUNK) begin
            state_d = rgsc_pkg::ST_EMIT;
            step_d  = '0;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
        rgsc_pkg::ST_EMIT: begin
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            state_d    = sts_i.last ? rgsc_pkg::ST_IDLE : rgsc_pkg::ST_TRY;
          end
        end
        rgsc_pkg::ST_EMPTY: begin
          if (sts_i.out_free) begin
            cmd_o.emit_empty = 1'b1;
            state_d          = rgsc_pkg::ST_IDLE;
          end
        end
        default: begin
          state_d = rgsc_pkg::ST_IDLE;
          step_d  = '0;
        end
      endcase
    end
  end

  // Checks
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == rgsc_pkg::ST_START)
    else $error("accepted trial did not start");

  a_seed_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.seed_wr |=> (state_q == rgsc_pkg::ST_SEED_MUL) && (step_q == '0))
    else $error("seed write did not restart reseed");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rgsc_pkg::ST_DIV |-> !sts_i.cnt_zero)
    else $error("modulo by zero count");

endmodule

// ----- src/rgsc_dp.sv -----
module rgsc_dp #(
  parameter int MAX_N = rgsc_pkg::MAX_N_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rgsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rgsc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [rgsc_pkg::TAG_W-1:0]      in_tag_i,
  input  rgsc_pkg::cmd_t                  cmd_i,
  output rgsc_pkg::sts_t                  sts_o,
  output rgsc_pkg::res_t                  res_o,
  output logic                            res_valid_o,
  input  logic                            res_ready_i
);

  localparam int CAND_W = (MAX_N < 3) ? rgsc_pkg::LANES : (1 << MAX_N);
  localparam int CHUNKS = CAND_W / rgsc_pkg::LANES;
  localparam int CH_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int MW     = rgsc_pkg::MASK_W;
  localparam int CW     = rgsc_pkg::CNT_W;

  // Configuration registers
  logic [2:0]  set_size_q;
  logic [2:0]  subset_size_q;
  logic [7:0]  allowed_q;
  logic [63:0] seed_q;

  // Working state
  logic [63:0]                  rng_q, rng_d;
  logic [63:0]                  prod_q, prod_d;
  logic [31:0]                  div_q, div_d;
  logic [CW-1:0]                rem_q, rem_d;
  logic [CAND_W-1:0]            cand_q, cand_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic [CW-1:0]                found_q, found_d;
  logic [CW-1:0]                best_q, best_d;
  logic [MW-1:0]                v_q, v_d;
  logic                         selfound_q, selfound_d;
  logic [rgsc_pkg::TAG_W-1:0]   tag_q, tag_d;
  logic                         out_valid_q, out_valid_d;
  rgsc_pkg::res_t               res_q, res_d;

  // Combinational helpers
  logic                         seed_wr;
  logic [2:0]                   n_eff;
  logic [CH_W-1:0]              chunk;
  logic [MW-1:0]                base;
  logic [rgsc_pkg::LANES-1:0]   low;
  logic [rgsc_pkg::LANES-1:0]   newlow;
  logic [3:0]                   low_cnt;
  logic [3:0]                   new_cnt;
  logic [CW-1:0]                run;
  logic                         hit;
  logic [rgsc_pkg::LANE_W-1:0]  lane;
  logic [CAND_W-1:0]            fill;
  logic [CAND_W-1:0]            rot_sel;
  logic [CAND_W-1:0]            rot_nar;
  logic [63:0]                  rng_next;
  logic [31:0]                  mul_a, mul_b;
  logic [6:0]                   t1, t2;
  logic [5:0]                   r1;
  logic [CW-1:0]                found_inc;
  logic                         nb;
  logic                         is_last;

  assign seed_wr = cfg_we_i &&
                   (rgsc_pkg::cfg_reg_e'(cfg_idx_i) == rgsc_pkg::CFG_SEED);
  assign n_eff   = (set_size_q > 3'(MAX_N)) ? 3'(MAX_N) : set_size_q;
  assign chunk   = cmd_i.step[CH_W-1:0];
  assign base    = MW'(chunk) << rgsc_pkg::LANE_W;
  assign low     = cand_q[rgsc_pkg::LANES-1:0];
  assign low_cnt = rgsc_pkg::popcnt8(low);
  assign new_cnt = rgsc_pkg::popcnt8(newlow);
  assign rng_next = rgsc_pkg::xs_step(rng_q);
  assign found_inc = found_q + 1'b1;
  assign nb        = found_inc > best_q;
  assign is_last   = (cnt_q == '0) || (found_q == rgsc_pkg::MAX_RESULTS - 1'b1);

  assign sts_o.seed_wr  = seed_wr;
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.last     = is_last;
  assign sts_o.out_free = !out_valid_q || res_ready_i;

  assign res_o       = res_q;
  assign res_valid_o = out_valid_q;

  // Initial candidate set: every k-subset of the n-set
  always_comb begin
    for (int m = 0; m < CAND_W; m++) begin
      fill[m] = ((8'(m) >> n_eff) == 8'd0) &&
                (rgsc_pkg::popcnt8(8'(m)) == {1'b0, subset_size_q});
    end
  end

  // Locate the chosen candidate inside the current chunk
  always_comb begin
    run  = '0;
    hit  = 1'b0;
    lane = '0;
    for (int j = 0; j < rgsc_pkg::LANES; j++) begin
      if (low[j] && !hit && (run == rem_q)) begin
        hit  = 1'b1;
        lane = rgsc_pkg::LANE_W'(j);
      end
      run = run + {{(CW-1){1'b0}}, low[j]};
    end
  end

  // Keep only neighbours of the picked member
  always_comb begin
    for (int j = 0; j < rgsc_pkg::LANES; j++) begin
      newlow[j] = low[j] && rgsc_pkg::adjacent(base | MW'(j), v_q, allowed_q);
    end
  end

  // Chunk rotation: low chunk goes back in at the top
  assign rot_sel = (CAND_W'(low) << (CAND_W - rgsc_pkg::LANES)) | (cand_q >> rgsc_pkg::LANES);
  assign rot_nar = (CAND_W'(newlow) << (CAND_W - rgsc_pkg::LANES)) |
                   (cand_q >> rgsc_pkg::LANES);

  // Shared 32x32 multiplier for the reseed product
  always_comb begin
    case (cmd_i.step[1:0])
      2'd0:    begin mul_a = seed_q[31:0];  mul_b = rgsc_pkg::SEED_MULT[31:0];  end
      2'd1:    begin mul_a = seed_q[31:0];  mul_b = rgsc_pkg::SEED_MULT[63:32]; end
      2'd2:    begin mul_a = seed_q[63:32]; mul_b = rgsc_pkg::SEED_MULT[31:0];  end
      default: begin mul_a = seed_q[63:32]; mul_b = rgsc_pkg::SEED_MULT[31:0];  end
    endcase
  end

  // Two restoring modulo steps per cycle
  always_comb begin
    t1 = {rem_q, div_q[31]};
    if (t1 >= {1'b0, cnt_q}) begin
      t1 = t1 - {1'b0, cnt_q};
    end
    r1 = t1[5:0];
    t2 = {r1, div_q[30]};
    if (t2 >= {1'b0, cnt_q}) begin
      t2 = t2 - {1'b0, cnt_q};
    end
  end

  // Datapath next state
  always_comb begin
    rng_d       = rng_q;
    prod_d      = prod_q;
    div_d       = div_q;
    rem_d       = rem_q;
    cand_d      = cand_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    best_d      = best_q;
    v_d         = v_q;
    selfound_d  = selfound_q;
    tag_d       = tag_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !res_ready_i;

    if (seed_wr) begin
      best_d = '0;
    end

    if (cmd_i.accept) begin
      tag_d = in_tag_i;
    end

    if (cmd_i.mul) begin
      prod_d = mul_a * mul_b;
      case (cmd_i.step[1:0])
        2'd0:    rng_d = rng_q;
        2'd1:    rng_d = prod_q + rgsc_pkg::SEED_ADD;
        default: rng_d = rng_q + {prod_q[31:0], 32'd0};
      endcase
    end

    if (cmd_i.draw) begin
      rng_d = rng_next;
      div_d = rng_next[63:32];
      rem_d = '0;
    end

    if (cmd_i.start) begin
      cand_d  = fill;
      cnt_d   = rgsc_pkg::BINOM[n_eff][subset_size_q];
      found_d = '0;
    end

    if (cmd_i.div) begin
      div_d = div_q << 2;
      rem_d = t2[5:0];
    end

    if (cmd_i.sel) begin
      cand_d = rot_sel;
      if ((chunk == '0) || !selfound_q) begin
        if (hit) begin
          v_d        = base | MW'(lane);
          selfound_d = 1'b1;
        end else begin
          rem_d      = rem_q - {2'b00, low_cnt};
          selfound_d = 1'b0;
        end
      end
    end

    if (cmd_i.narrow) begin
      cand_d = rot_nar;
      cnt_d  = ((chunk == '0) ? '0 : cnt_q) + {2'b00, new_cnt};
    end

    if (cmd_i.emit) begin
      res_d.tag          = tag_q;
      res_d.member_mask  = v_q;
      res_d.member_valid = 1'b1;
      res_d.position     = found_q;
      res_d.clique_size  = is_last ? found_inc : '0;
      res_d.new_best     = is_last && nb;
      res_d.best_size    = is_last ? (nb ? found_inc : best_q) : '0;
      res_d.last         = is_last;
      out_valid_d        = 1'b1;
      found_d            = found_inc;
      if (is_last && nb) begin
        best_d = found_inc;
      end
    end

    if (cmd_i.emit_empty) begin
      res_d.tag          = tag_q;
      res_d.member_mask  = '0;
      res_d.member_valid = 1'b0;
      res_d.position     = '0;
      res_d.clique_size  = '0;
      res_d.new_best     = 1'b0;
      res_d.best_size    = best_q;
      res_d.last         = 1'b1;
      out_valid_d        = 1'b1;
    end
  end

  // Configuration and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q    <= 3'd7;
      subset_size_q <= 3'd3;
      allowed_q     <= '0;
      seed_q        <= '0;
      rng_q         <= rgsc_pkg::RNG_RESET;
      rem_q         <= '0;
      cand_q        <= '0;
      cnt_q         <= '0;
      found_q       <= '0;
      best_q        <= '0;
      selfound_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (rgsc_pkg::cfg_reg_e'(cfg_idx_i))
          rgsc_pkg::CFG_SET_SIZE:    set_size_q    <= cfg_data_i[2:0];
          rgsc_pkg::CFG_SUBSET_SIZE: subset_size_q <= cfg_data_i[2:0];
          rgsc_pkg::CFG_ALLOWED:     allowed_q     <= cfg_data_i[7:0];
          rgsc_pkg::CFG_SEED:        seed_q        <= cfg_data_i;
          default: ;
        endcase
      end
      rng_q       <= rng_d;
      rem_q       <= rem_d;
      cand_q      <= cand_d;
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      best_q      <= best_d;
      selfound_q  <= selfound_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    div_q  <= div_d;
    v_q    <= v_d;
    tag_q  <= tag_d;
    res_q  <= res_d;
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= rgsc_pkg::MAX_RESULTS)
    else $error("candidate count out of range");

  a_size_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.last && res_q.member_valid |->
      res_q.clique_size == res_q.position + 1'b1)
    else $error("clique size disagrees with last position");

  a_best_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.last |-> res_q.best_size >= res_q.clique_size)
    else $error("best size below trial size");

endmodule

// ----- src/random_greedy_subset_clique_top.sv -----
// Randomized greedy clique search on the graph of k-subsets of an n-set.
// trial_i: one transfer starts one greedy trial, tagged by trial_tag.
// result_o: one transfer per clique member in pick order; the final one has
//   last set and carries clique_size, best_size and new_best. With no vertex
//   (k > n) a trial gives a single result with member_valid low.
// cfg_we_i/cfg_idx_i/cfg_data_i: register writes (set_size, subset_size,
//   allowed_sizes, seed), which the user must make only between trials;
//   the block itself does not enforce this.
// Steps: build the candidate set, then per member a generator draw, the
//   modulo steps (2 quotient bits per cycle), a scan of the candidate vector
//   8 bits at a time for the pick and another for the neighbour filter, and
//   the load of the result.
// A new trial is accepted once the last result is loaded, even while it
//   waits at the output. A stalled receiver holds the block in its emit step.
// A seed write runs the multiply and 40 generator steps; trial_i.ready
//   stays low in the write cycle and until those steps finish, and
//   best_size is cleared.
// Reset loads the register defaults and the generator state of seed zero, so
//   the first trial can be taken right away.
module random_greedy_subset_clique_top #(
  parameter int MAX_N = rgsc_pkg::MAX_N_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rgsc_trial_if.sink                      trial_i,
  rgsc_result_if.source                   result_o,
  input  logic                            cfg_we_i,
  input  logic [rgsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rgsc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  rgsc_pkg::cmd_t cmd;
  rgsc_pkg::sts_t sts;
  rgsc_pkg::res_t res;
  logic           res_valid;
  logic           in_ready;

  rgsc_ctrl #(
    .MAX_N (MAX_N)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (trial_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rgsc_dp #(
    .MAX_N (MAX_N)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_tag_i    (trial_i.trial_tag),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (result_o.ready)
  );

  // Channel hookup
  assign trial_i.ready         = in_ready;
  assign result_o.valid        = res_valid;
  assign result_o.tag          = res.tag;
  assign result_o.member_mask  = res.member_mask;
  assign result_o.member_valid = res.member_valid;
  assign result_o.position     = res.position;
  assign result_o.clique_size  = res.clique_size;
  assign result_o.new_best     = res.new_best;
  assign result_o.best_size    = res.best_size;
  assign result_o.last         = res.last;

endmodule
